>>> hw/rtl/slbm_pkg.sv
// slbm_pkg: shared types and constants for the serial loaded bank mapper
// no dependencies; imported by the interfaces, the mapper modules and the checker
package slbm_pkg;

    typedef enum logic [1:0] {
        FUNC_CPU_READ  = 2'd0,
        FUNC_CPU_WRITE = 2'd1,
        FUNC_PPU_READ  = 2'd2,
        FUNC_UNUSED    = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        TGT_NONE    = 2'd0,
        TGT_PRG_RAM = 2'd1,
        TGT_PRG_ROM = 2'd2,
        TGT_CHR     = 2'd3
    } target_t;

    // register chosen by address bits 14-13 on the fifth serial bit
    typedef enum logic [1:0] {
        SEL_CONTROL  = 2'd0,
        SEL_CHR_LOW  = 2'd1,
        SEL_CHR_HIGH = 2'd2,
        SEL_PRG      = 2'd3
    } reg_sel_t;

    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 8;
    localparam int MAP_W      = 18;
    localparam int BANKS_W    = 5;
    localparam int SERIAL_W   = 5;
    localparam int COUNT_W    = 3;
    localparam int MAX_BANKS  = 16;
    localparam int PRG_RAM_AW = 13;

    localparam logic [COUNT_W-1:0]  SERIAL_LAST   = 3'd4;
    localparam logic [BANKS_W-1:0]  BANKS_RESET   = 5'd16;
    localparam logic [SERIAL_W-1:0] CONTROL_RESET = 5'h0C;

    typedef struct packed {
        logic [1:0] mirroring;
        logic [1:0] prg_mode;
        logic       chr_mode;
        logic [4:0] chr_select_low;
        logic [4:0] chr_select_high;
        logic [3:0] prg_select;
        logic       ram_enabled;
    } bank_state_t;

endpackage

>>> hw/rtl/slbm_access_if.sv
// slbm_access_if: bus access channel, one access per beat
// depends on slbm_pkg
interface slbm_access_if
    import slbm_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [1:0]          func;
    logic [ADDR_W-1:0]   bus_addr;
    logic [DATA_W-1:0]   write_data;

    modport source (output valid, output func, output bus_addr, output write_data,
                    input ready);
    modport sink   (input valid, input func, input bus_addr, input write_data,
                    output ready);
endinterface

>>> hw/rtl/slbm_result_if.sv
// slbm_result_if: mapping result channel, one result per beat
// depends on slbm_pkg
interface slbm_result_if
    import slbm_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [1:0]        target;
    logic [MAP_W-1:0]  mapped_addr;
    logic              ram_write;
    logic [1:0]        mirror_mode;

    modport source (output valid, output target, output mapped_addr, output ram_write,
                    output mirror_mode, input ready);
    modport sink   (input valid, input target, input mapped_addr, input ram_write,
                    input mirror_mode, output ready);
endinterface

>>> hw/rtl/slbm_regs.sv
// slbm_regs: serial shift register and the four bank registers it loads
// depends on slbm_pkg
module slbm_regs
    import slbm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [1:0]          func,
    input  logic [ADDR_W-1:0]   bus_addr,
    input  logic [DATA_W-1:0]   write_data,
    output bank_state_t         state,
    output bank_state_t         state_next
);

    logic [SERIAL_W-1:0] serial_reg, serial_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    bank_state_t         bank_reg, bank_next;
    logic [SERIAL_W-1:0] shifted;
    reg_sel_t            sel;

    assign shifted = {write_data[0], serial_reg[SERIAL_W-1:1]};
    assign sel     = reg_sel_t'(bus_addr[14:13]);

    always_comb
    begin
        serial_next = serial_reg;
        count_next  = count_reg;
        bank_next   = bank_reg;
        if (accept && func_t'(func) == FUNC_CPU_WRITE && bus_addr[ADDR_W-1])
        begin
            if (write_data[DATA_W-1])
            begin
                serial_next        = '0;
                count_next         = '0;
                bank_next.mirroring = CONTROL_RESET[1:0];
                bank_next.prg_mode  = CONTROL_RESET[3:2];
                bank_next.chr_mode  = CONTROL_RESET[4];
            end
            else if (count_reg == SERIAL_LAST)
            begin
                // fifth bit: commit and start over
                serial_next = '0;
                count_next  = '0;
                unique case (sel)
                    SEL_CONTROL:
                    begin
                        bank_next.mirroring = shifted[1:0];
                        bank_next.prg_mode  = shifted[3:2];
                        bank_next.chr_mode  = shifted[4];
                    end
                    SEL_CHR_LOW:  bank_next.chr_select_low  = shifted;
                    SEL_CHR_HIGH: bank_next.chr_select_high = shifted;
                    SEL_PRG:
                    begin
                        bank_next.prg_select  = shifted[3:0];
                        bank_next.ram_enabled = ~shifted[4];
                    end
                    default: bank_next = bank_reg;
                endcase
            end
            else
            begin
                serial_next = shifted;
                count_next  = count_reg + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            serial_reg           <= '0;
            count_reg            <= '0;
            bank_reg.mirroring   <= CONTROL_RESET[1:0];
            bank_reg.prg_mode    <= CONTROL_RESET[3:2];
            bank_reg.chr_mode    <= CONTROL_RESET[4];
            bank_reg.chr_select_low  <= '0;
            bank_reg.chr_select_high <= '0;
            bank_reg.prg_select  <= '0;
            bank_reg.ram_enabled <= 1'b0;
        end
        else
        begin
            serial_reg <= serial_next;
            count_reg  <= count_next;
            bank_reg   <= bank_next;
        end
    end

    assign state      = bank_reg;
    assign state_next = bank_next;

endmodule

>>> hw/rtl/slbm_map.sv
// slbm_map: decodes one access and forms the prg or chr byte offset
// depends on slbm_pkg; purely combinational
module slbm_map
    import slbm_pkg::*;
(
    input  logic [1:0]          func,
    input  logic [ADDR_W-1:0]   bus_addr,
    input  bank_state_t         state,
    input  logic [BANKS_W-1:0]  prg_rom_banks,
    output logic [1:0]          target,
    output logic [MAP_W-1:0]    mapped_addr,
    output logic                ram_write
);

    logic        in_ram;
    logic        upper;
    logic [3:0]  last_bank;
    logic [3:0]  rom_bank;
    logic [MAP_W-1:0] prg_off;
    logic [MAP_W-1:0] chr_off;
    logic [MAP_W-1:0] ram_off;

    // 0 counts as one bank, anything above 16 as 16
    always_comb
    begin
        if (prg_rom_banks == '0)
            last_bank = '0;
        else if (prg_rom_banks > BANKS_W'(MAX_BANKS))
            last_bank = 4'(MAX_BANKS - 1);
        else
            last_bank = 4'(prg_rom_banks - BANKS_W'(1));
    end

    assign in_ram = (bus_addr[15:13] == 3'b011);
    assign upper  = bus_addr[14];

    always_comb
    begin
        if (!state.prg_mode[1])
            rom_bank = {state.prg_select[3:1], upper};
        else if (state.prg_mode == 2'd2)
            rom_bank = upper ? state.prg_select : 4'd0;
        else
            rom_bank = upper ? last_bank : state.prg_select;
    end

    assign prg_off = {rom_bank, bus_addr[13:0]};
    assign ram_off = MAP_W'(bus_addr[PRG_RAM_AW-1:0]);

    always_comb
    begin
        if (!state.chr_mode)
            chr_off = MAP_W'({state.chr_select_low[4:1], bus_addr[12:0]});
        else if (!bus_addr[12])
            chr_off = MAP_W'({state.chr_select_low, bus_addr[11:0]});
        else
            chr_off = MAP_W'({state.chr_select_high, bus_addr[11:0]});
    end

    always_comb
    begin
        target      = TGT_NONE;
        mapped_addr = '0;
        ram_write   = 1'b0;
        unique case (func_t'(func))
            FUNC_CPU_READ:
            begin
                if (in_ram)
                begin
                    if (state.ram_enabled)
                    begin
                        target      = TGT_PRG_RAM;
                        mapped_addr = ram_off;
                    end
                end
                else if (bus_addr[15])
                begin
                    target      = TGT_PRG_ROM;
                    mapped_addr = prg_off;
                end
            end
            FUNC_CPU_WRITE:
            begin
                if (in_ram && state.ram_enabled)
                begin
                    target      = TGT_PRG_RAM;
                    mapped_addr = ram_off;
                    ram_write   = 1'b1;
                end
            end
            FUNC_PPU_READ:
            begin
                if (bus_addr[15:13] == 3'b000)
                begin
                    target      = TGT_CHR;
                    mapped_addr = chr_off;
                end
            end
            default:
            begin
                target = TGT_NONE;
            end
        endcase
    end

endmodule

>>> hw/rtl/serial_loaded_bank_mapper.sv
// channel  | dir  | beat contents
// ---------+------+--------------------------------------------
// access   | sink | func, bus_addr, write_data
// result   | src  | target, mapped_addr, ram_write, mirror_mode
// cfg      | in   | cfg_we, cfg_wdata (prg_rom_banks)
//
// one access per clock unless access.ready is low; its result appears in the output register in the next cycle
// the bank registers update at the accepting edge, so back-to-back accesses see
// each other's writes; mirror_mode already reflects the access it comes with
// access.ready drops only while a result is held and result.ready is low
// reset loads control 0x0C, clears the serial register and banks, prg_rom_banks 16
// depends on slbm_pkg, slbm_access_if, slbm_result_if, slbm_regs, slbm_map
module serial_loaded_bank_mapper
    import slbm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    slbm_access_if.sink          access,
    slbm_result_if.source        result,
    input  logic                 cfg_we,
    input  logic [BANKS_W-1:0]   cfg_wdata
);

    logic [BANKS_W-1:0] banks_reg;
    logic               valid_reg;
    logic [1:0]         target_reg;
    logic [MAP_W-1:0]   mapped_reg;
    logic               ram_write_reg;
    logic [1:0]         mirror_reg;

    logic               accept;
    bank_state_t        state, state_next;
    logic [1:0]         target;
    logic [MAP_W-1:0]   mapped_addr;
    logic               ram_write;

    assign access.ready = ~valid_reg | result.ready;
    assign accept       = access.valid & access.ready;

    slbm_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .func       (access.func),
        .bus_addr   (access.bus_addr),
        .write_data (access.write_data),
        .state      (state),
        .state_next (state_next)
    );

    slbm_map u_map (
        .func          (access.func),
        .bus_addr      (access.bus_addr),
        .state         (state),
        .prg_rom_banks (banks_reg),
        .target        (target),
        .mapped_addr   (mapped_addr),
        .ram_write     (ram_write)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            banks_reg <= BANKS_RESET;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                banks_reg <= cfg_wdata;
            if (accept)
                valid_reg <= 1'b1;
            else if (result.ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            target_reg    <= target;
            mapped_reg    <= mapped_addr;
            ram_write_reg <= ram_write;
            mirror_reg    <= state_next.mirroring;
        end
    end

    assign result.valid       = valid_reg;
    assign result.target      = target_reg;
    assign result.mapped_addr = mapped_reg;
    assign result.ram_write   = ram_write_reg;
    assign result.mirror_mode = mirror_reg;

endmodule

>>> hw/rtl/slbm_checker.sv
// slbm_checker: port-level checks for the bank mapper, bound to the top level
// depends on slbm_pkg and serial_loaded_bank_mapper
module slbm_checker
    import slbm_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               acc_valid,
    input logic               acc_ready,
    input logic [1:0]         acc_func,
    input logic [ADDR_W-1:0]  acc_addr,
    input logic [DATA_W-1:0]  acc_data,
    input logic               res_valid,
    input logic               res_ready,
    input logic [1:0]         res_target,
    input logic [MAP_W-1:0]   res_mapped,
    input logic               res_ram_write,
    input logic [1:0]         res_mirror
);

    logic acc_beat;
    logic reg_write;

    assign acc_beat  = acc_valid & acc_ready;
    assign reg_write = acc_beat && func_t'(acc_func) == FUNC_CPU_WRITE && acc_addr[15];

    // a held result stays put until taken
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_mapped) && $stable(res_target))
        else $error("result changed while stalled");

    a_beat_result: assert property (@(posedge clk) disable iff (!rst_n)
        acc_beat |=> res_valid)
        else $error("accepted access gave no result");

    a_serial_none: assert property (@(posedge clk) disable iff (!rst_n)
        reg_write |=> res_target == TGT_NONE && res_mapped == '0 && !res_ram_write)
        else $error("mapper register write produced a memory target");

    a_reset_write: assert property (@(posedge clk) disable iff (!rst_n)
        reg_write && acc_data[7] |=> res_mirror == CONTROL_RESET[1:0])
        else $error("serial reset did not restore control");

    a_ram_write: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ram_write |-> res_target == TGT_PRG_RAM)
        else $error("ram write outside prg ram");

endmodule

bind serial_loaded_bank_mapper slbm_checker u_slbm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .acc_valid     (access.valid),
    .acc_ready     (access.ready),
    .acc_func      (access.func),
    .acc_addr      (access.bus_addr),
    .acc_data      (access.write_data),
    .res_valid     (result.valid),
    .res_ready     (result.ready),
    .res_target    (result.target),
    .res_mapped    (result.mapped_addr),
    .res_ram_write (result.ram_write),
    .res_mirror    (result.mirror_mode)
);

>>> tb/slbm_map_check.sv
`timescale 1ns / 100ps
// slbm_map_check: watches the access and result channels of the bank mapper, predicts
// every result from its own copy of the bank registers and compares beat by beat
// depends on slbm_pkg, slbm_access_if, slbm_result_if
module slbm_map_check
    import slbm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    slbm_access_if             access,
    slbm_result_if             result,
    input  logic               cfg_we,
    input  logic [BANKS_W-1:0] cfg_wdata,
    output int unsigned        fail_count,
    output int unsigned        maps_due
);

    localparam int REPORT_MAX = 10;

    localparam logic [1:0] PRG_FIX_FIRST = 2'd2;
    localparam logic [1:0] PRG_FIX_LAST  = 2'd3;
    localparam logic       CHR_8K        = 1'b0;

    localparam logic [ADDR_W-1:0] RAM_BASE = 16'h6000;
    localparam logic [ADDR_W-1:0] RAM_TOP  = 16'h7FFF;
    localparam logic [ADDR_W-1:0] CHR_TOP  = 16'h1FFF;

    typedef struct packed {
        target_t          target;
        logic [MAP_W-1:0] mapped_addr;
        logic             ram_write;
        logic [1:0]       mirror_mode;
    } bus_map_t;

    bank_state_t         regs;
    logic [SERIAL_W-1:0] shift_bits;
    logic [COUNT_W-1:0]  shift_count;
    logic [BANKS_W-1:0]  rom_banks;
    bus_map_t            due_maps[$];
    int unsigned         fails = 0;

    function automatic void load_control(input logic [SERIAL_W-1:0] v);
        regs.mirroring = v[1:0];
        regs.prg_mode  = v[3:2];
        regs.chr_mode  = v[4];
    endfunction

    function automatic logic [3:0] fixed_last_bank();
        logic [BANKS_W-1:0] n;
        n = rom_banks;
        if (n == '0)
            n = BANKS_W'(1);
        if (n > BANKS_W'(MAX_BANKS))
            n = BANKS_W'(MAX_BANKS);
        return 4'(n - BANKS_W'(1));
    endfunction

    function automatic logic [MAP_W-1:0] prg_rom_offset(input logic [ADDR_W-1:0] a);
        logic [3:0] bank;
        case (regs.prg_mode)
            PRG_FIX_FIRST: bank = a[14] ? regs.prg_select : 4'd0;
            PRG_FIX_LAST:  bank = a[14] ? fixed_last_bank() : regs.prg_select;
            // 32k mode ignores the low select bit
            default:       bank = {regs.prg_select[3:1], a[14]};
        endcase
        return {bank, a[13:0]};
    endfunction

    function automatic logic [MAP_W-1:0] chr_offset(input logic [ADDR_W-1:0] a);
        logic [MAP_W-1:0] off;
        if (regs.chr_mode == CHR_8K)
            off = MAP_W'({regs.chr_select_low[4:1], a[12:0]});
        else if (!a[12])
            off = MAP_W'({regs.chr_select_low, a[11:0]});
        else
            off = MAP_W'({regs.chr_select_high, a[11:0]});
        return off;
    endfunction

    function automatic void shift_in(input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d);
        logic [SERIAL_W-1:0] v;
        if (d[7])
        begin
            shift_bits  = '0;
            shift_count = '0;
            load_control(CONTROL_RESET);
        end
        else
        begin
            v = {d[0], shift_bits[SERIAL_W-1:1]};
            if (shift_count == SERIAL_LAST)
            begin
                case (reg_sel_t'(a[14:13]))
                    SEL_CONTROL:  load_control(v);
                    SEL_CHR_LOW:  regs.chr_select_low = v;
                    SEL_CHR_HIGH: regs.chr_select_high = v;
                    default:
                    begin
                        regs.prg_select  = v[3:0];
                        regs.ram_enabled = ~v[4];
                    end
                endcase
                shift_bits  = '0;
                shift_count = '0;
            end
            else
            begin
                shift_bits  = v;
                shift_count = shift_count + 1'b1;
            end
        end
    endfunction

    function automatic bus_map_t map_access(input func_t f, input logic [ADDR_W-1:0] a,
                                            input logic [DATA_W-1:0] d);
        bus_map_t m;
        logic     in_ram;
        m.target      = TGT_NONE;
        m.mapped_addr = '0;
        m.ram_write   = 1'b0;
        in_ram = (a >= RAM_BASE) && (a <= RAM_TOP);
        case (f)
            FUNC_CPU_READ, FUNC_CPU_WRITE:
            begin
                if (in_ram)
                begin
                    if (regs.ram_enabled)
                    begin
                        m.target      = TGT_PRG_RAM;
                        m.mapped_addr = MAP_W'(a[PRG_RAM_AW-1:0]);
                        m.ram_write   = (f == FUNC_CPU_WRITE);
                    end
                end
                else if (a[15])
                begin
                    if (f == FUNC_CPU_READ)
                    begin
                        m.target      = TGT_PRG_ROM;
                        m.mapped_addr = prg_rom_offset(a);
                    end
                    else
                        shift_in(a, d);
                end
            end
            FUNC_PPU_READ:
            begin
                if (a <= CHR_TOP)
                begin
                    m.target      = TGT_CHR;
                    m.mapped_addr = chr_offset(a);
                end
            end
            default: ;
        endcase
        // mirroring as it stands after this access
        m.mirror_mode = regs.mirroring;
        return m;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        bus_map_t want;
        bus_map_t got;
        if (!rst_n)
        begin
            regs        = '0;
            load_control(CONTROL_RESET);
            shift_bits  = '0;
            shift_count = '0;
            rom_banks   = BANKS_RESET;
            due_maps.delete();
        end
        else
        begin
            if (cfg_we)
                rom_banks = cfg_wdata;
            if (result.valid && result.ready)
            begin
                got.target      = target_t'(result.target);
                got.mapped_addr = result.mapped_addr;
                got.ram_write   = result.ram_write;
                got.mirror_mode = result.mirror_mode;
                if (due_maps.size() == 0)
                begin
                    fails++;
                    if (fails <= REPORT_MAX)
                        $display("%0t: result beat with nothing pending: target %0d addr %05h",
                                 $time, got.target, got.mapped_addr);
                end
                else
                begin
                    want = due_maps.pop_front();
                    if (got !== want)
                    begin
                        fails++;
                        if (fails <= REPORT_MAX)
                            $display("%0t: mismatch: expected target %0d addr %05h ",
                                     $time, want.target, want.mapped_addr,
                                     "wr %0d mirror %0d, ",
                                     want.ram_write, want.mirror_mode,
                                     "got target %0d addr %05h wr %0d mirror %0d",
                                     got.target, got.mapped_addr,
                                     got.ram_write, got.mirror_mode);
                    end
                end
            end
            if (access.valid && access.ready)
                due_maps.push_back(map_access(func_t'(access.func), access.bus_addr,
                                              access.write_data));
        end
        fail_count <= fails;
        maps_due   <= due_maps.size();
    end

endmodule

>>> tb/tb_serial_loaded_bank_mapper.sv
`timescale 1ns / 100ps
// tb_serial_loaded_bank_mapper: clock, reset, bus access stimulus and verdict for the mapper
// depends on slbm_pkg, slbm_access_if, slbm_result_if, serial_loaded_bank_mapper, slbm_map_check
module tb_serial_loaded_bank_mapper;
    import slbm_pkg::*;

    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 190;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 250;
    localparam int IDLE_PCT    = 20;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [BANKS_W-1:0] cfg_wdata;
    logic               quiet = 1'b0;
    int unsigned        fail_count;
    int unsigned        maps_due;
    int unsigned        idle_run;

    logic [BANKS_W-1:0] bank_plan [PHASES] = '{5'd1, 5'd0, 5'd31, 5'd17, 5'd9, 5'd16};

    slbm_access_if access_ch ();
    slbm_result_if result_ch ();

    serial_loaded_bank_mapper uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .access    (access_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    slbm_map_check map_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .access     (access_ch),
        .result     (result_ch),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .maps_due   (maps_due)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // watchdog: cycles in a row with no beat on either channel
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_run <= 0;
        else if ((access_ch.valid && access_ch.ready) || (result_ch.valid && result_ch.ready))
            idle_run <= 0;
        else
        begin
            idle_run <= idle_run + 1;
            if (idle_run >= STALL_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // result side: random back-pressure plus one long hold-off
    initial
    begin
        int unsigned beats;
        logic        held;
        beats = 0;
        held  = 1'b0;
        result_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (result_ch.valid && result_ch.ready)
                beats++;
            if (!held && beats >= HOLD_AT)
            begin
                held = 1'b1;
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            result_ch.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    task automatic send_access(input func_t f, input logic [ADDR_W-1:0] a,
                               input logic [DATA_W-1:0] d);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT)
        begin
            access_ch.valid <= 1'b0;
            @(posedge clk);
        end
        access_ch.valid      <= 1'b1;
        access_ch.func       <= f;
        access_ch.bus_addr   <= a;
        access_ch.write_data <= d;
        do
            @(posedge clk);
        while (!access_ch.ready);
    endtask

    // five serial beats, lsb first; the last address picks the register
    task automatic load_serial(input logic [ADDR_W-1:0] a, input logic [SERIAL_W-1:0] v);
        for (int i = 0; i < SERIAL_W; i++)
            send_access(FUNC_CPU_WRITE, a, 8'h7E | v[i]);
    endtask

    task automatic pick_access(output func_t f, output logic [ADDR_W-1:0] a,
                               output logic [DATA_W-1:0] d);
        int unsigned roll;
        int unsigned sub;
        roll = $urandom_range(0, 99);
        sub  = $urandom_range(0, 39);
        a    = ADDR_W'($urandom());
        d    = DATA_W'($urandom());
        if (roll < 30)
        begin
            f = FUNC_CPU_READ;
            if (sub < 24)
                a[15] = 1'b1;
            else if (sub < 34)
                a[15:13] = 3'b011;
        end
        else if (roll < 55)
        begin
            f = FUNC_PPU_READ;
            if (sub < 34)
                a[15:13] = 3'b000;
        end
        else if (roll < 90)
        begin
            f = FUNC_CPU_WRITE;
            if (sub == 0)
            begin
                // serial reset
                a[15] = 1'b1;
                d[7]  = 1'b1;
            end
            else if (sub < 32)
            begin
                a[15] = 1'b1;
                d[7]  = 1'b0;
            end
            else if (sub < 38)
                a[15:13] = 3'b011;
        end
        else
            f = FUNC_UNUSED;
    endtask

    task automatic drain_results();
        access_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (maps_due != 0);
        repeat (2) @(posedge clk);
    endtask

    task automatic set_bank_count(input logic [BANKS_W-1:0] v);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        func_t              f;
        logic [ADDR_W-1:0]  a;
        logic [DATA_W-1:0]  d;
        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_wdata            <= BANKS_RESET;
        access_ch.valid      <= 1'b0;
        access_ch.func       <= FUNC_CPU_READ;
        access_ch.bus_addr   <= '0;
        access_ch.write_data <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed part, bank count at its reset value
        send_access(FUNC_CPU_READ, 16'h0000, 8'h00);
        send_access(FUNC_CPU_READ, 16'h5FFF, 8'h00);
        send_access(FUNC_CPU_READ, 16'h6000, 8'h00);
        send_access(FUNC_CPU_WRITE, 16'h7FFF, 8'hFF);
        send_access(FUNC_CPU_READ, 16'h8000, 8'h00);
        send_access(FUNC_CPU_READ, 16'hFFFF, 8'h00);
        send_access(FUNC_PPU_READ, 16'h0000, 8'h00);
        send_access(FUNC_PPU_READ, 16'h1FFF, 8'h00);
        send_access(FUNC_PPU_READ, 16'h2000, 8'h00);
        send_access(FUNC_UNUSED, 16'hFFFF, 8'hFF);
        send_access(FUNC_CPU_WRITE, 16'h4020, 8'h01);
        send_access(FUNC_CPU_WRITE, 16'h8000, 8'h80);
        // prg bank 5, ram enabled
        load_serial(16'hE000, 5'h05);
        send_access(FUNC_CPU_WRITE, 16'h6000, 8'hA5);
        send_access(FUNC_CPU_READ, 16'h7FFF, 8'h00);
        // horizontal mirroring, first bank fixed, 4k chr
        load_serial(16'h8000, 5'h1B);
        send_access(FUNC_PPU_READ, 16'h1000, 8'h00);

        for (int p = 0; p < PHASES; p++)
        begin
            if (p == PHASES - 1)
                set_bank_count(BANKS_W'($urandom_range(0, 31)));
            else
                set_bank_count(bank_plan[p]);
            quiet = (p == 3);
            repeat (PHASE_ITEMS)
            begin
                pick_access(f, a, d);
                send_access(f, a, d);
            end
        end
        quiet = 1'b0;

        drain_results();
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
